### design/dwc_pkg.sv
// Shared types and constants for the detection window clustering block.
// Used by dwc_ctrl, dwc_dpath, the top level and the checker; no dependencies.
`default_nettype none
package dwc_pkg;

   localparam int DEF_MAX_ITEMS  = 64;
   localparam int DEF_COORD_BITS = 15;

   // Controller states, one-hot
   typedef enum logic [10:0] {
      ST_LOAD = 11'b000_0000_0001,
      ST_SEEK = 11'b000_0000_0010,
      ST_SRD  = 11'b000_0000_0100,
      ST_CRD  = 11'b000_0000_1000,
      ST_CMP  = 11'b000_0001_0000,
      ST_MUL1 = 11'b000_0010_0000,
      ST_MUL2 = 11'b000_0100_0000,
      ST_MUL3 = 11'b000_1000_0000,
      ST_TEST = 11'b001_0000_0000,
      ST_DIV  = 11'b010_0000_0000,
      ST_OUT  = 11'b100_0000_0000
   } state_type;

   // Operand select of the shared multiplier
   typedef enum logic [1:0] {
      MUL_INTER = 2'd0,
      MUL_CAND  = 2'd1,
      MUL_SEED  = 2'd2
   } mul_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic        load_wr;
      logic        drop;
      logic        clear;
      logic        seed_rst;
      logic        seed_inc;
      logic        rd_cand;
      logic        seed_take;
      logic        cand_inc;
      logic        cmp_take;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        test;
      logic        div_step;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic seed_end;
      logic seed_assigned;
      logic cand_end;
      logic cand_assigned;
      logic div_last;
   } status_type;

endpackage
`default_nettype wire

### design/dwc_ctrl.sv
// Controller of the clustering block: load, seed search, pair test, divide and output.
// Depends on dwc_pkg; drives dwc_dpath through cmd_type and reads status_type.
`default_nettype none
module dwc_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   input  wire                 req_last_item,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   input  wire                 count_full,
   input  dwc_pkg::status_type sts,
   output dwc_pkg::cmd_type    cmd
);

   dwc_pkg::state_type state_ff, state_in;
   logic req_beat, rsp_beat;

   assign req_stall = (state_ff != dwc_pkg::ST_LOAD);
   assign rsp_valid = (state_ff == dwc_pkg::ST_OUT);
   assign req_beat  = req_valid && !req_stall;
   assign rsp_beat  = rsp_valid && !rsp_stall;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.mul_sel = dwc_pkg::MUL_INTER;
      case (state_ff)
         dwc_pkg::ST_LOAD: begin
            if (req_beat) begin
               cmd.load_wr = !count_full;
               cmd.drop    = count_full;
               if (req_last_item) begin
                  cmd.seed_rst = 1'b1;
                  state_in     = dwc_pkg::ST_SEEK;
               end
            end
         end
         dwc_pkg::ST_SEEK: begin
            if (sts.seed_end) begin
               cmd.clear = 1'b1;
               state_in  = dwc_pkg::ST_LOAD;
            end else if (sts.seed_assigned) begin
               cmd.seed_inc = 1'b1;
            end else begin
               state_in = dwc_pkg::ST_SRD;
            end
         end
         dwc_pkg::ST_SRD: begin
            cmd.seed_take = 1'b1;
            state_in      = dwc_pkg::ST_CRD;
         end
         dwc_pkg::ST_CRD: begin
            cmd.rd_cand = 1'b1;
            if (sts.cand_end) begin
               state_in = dwc_pkg::ST_DIV;
            end else if (sts.cand_assigned) begin
               cmd.cand_inc = 1'b1;
            end else begin
               state_in = dwc_pkg::ST_CMP;
            end
         end
         dwc_pkg::ST_CMP: begin
            cmd.cmp_take = 1'b1;
            state_in     = dwc_pkg::ST_MUL1;
         end
         dwc_pkg::ST_MUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = dwc_pkg::MUL_INTER;
            state_in    = dwc_pkg::ST_MUL2;
         end
         dwc_pkg::ST_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = dwc_pkg::MUL_CAND;
            state_in    = dwc_pkg::ST_MUL3;
         end
         dwc_pkg::ST_MUL3: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = dwc_pkg::MUL_SEED;
            state_in    = dwc_pkg::ST_TEST;
         end
         dwc_pkg::ST_TEST: begin
            cmd.test     = 1'b1;
            cmd.cand_inc = 1'b1;
            state_in     = dwc_pkg::ST_CRD;
         end
         dwc_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = dwc_pkg::ST_OUT;
            end
         end
         dwc_pkg::ST_OUT: begin
            if (rsp_beat) begin
               cmd.seed_inc = 1'b1;
               state_in     = dwc_pkg::ST_SEEK;
            end
         end
         default: begin
            state_in = dwc_pkg::ST_LOAD;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dwc_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

### design/dwc_dpath.sv
// Datapath of the clustering block: box memory, assigned bits, IoU test, sums and divider.
// Depends on dwc_pkg; driven by dwc_ctrl through cmd_type.
`default_nettype none
module dwc_dpath #(
   parameter int MAX_ITEMS  = dwc_pkg::DEF_MAX_ITEMS,
   parameter int COORD_BITS = dwc_pkg::DEF_COORD_BITS
) (
   input  wire                     clock,
   input  wire                     reset,
   input  dwc_pkg::cmd_type        cmd,
   output dwc_pkg::status_type     sts,
   output logic                    count_full,
   input  wire  [COORD_BITS-1:0]   req_left,
   input  wire  [COORD_BITS-1:0]   req_top,
   input  wire  [COORD_BITS-1:0]   req_right,
   input  wire  [COORD_BITS-1:0]   req_bottom,
   output logic [COORD_BITS-1:0]   rsp_avg_left,
   output logic [COORD_BITS-1:0]   rsp_avg_top,
   output logic [COORD_BITS-1:0]   rsp_avg_right,
   output logic [COORD_BITS-1:0]   rsp_avg_bottom,
   output logic                    rsp_last_cluster,
   output logic                    rsp_overflow
);

   localparam int C   = COORD_BITS;
   localparam int AW  = $clog2(MAX_ITEMS);
   localparam int CW  = $clog2(MAX_ITEMS + 1);
   localparam int SW  = C + CW;
   localparam int DCW = $clog2(SW + 1);
   localparam int PW  = 2 * C + 2;
   localparam int TW  = PW + 4;

   // Box memory, one box per entry
   logic [4*C-1:0] mem [MAX_ITEMS];
   logic [4*C-1:0] rd_data_ff;
   logic [AW-1:0]  rd_addr;

   logic [CW-1:0]  count_ff, count_in;
   logic           dropped_ff, dropped_in;
   logic [CW-1:0]  seed_ff, seed_in;
   logic [CW-1:0]  cand_ff, cand_in;
   logic [MAX_ITEMS-1:0] assigned_ff, assigned_in;

   logic [C-1:0]   sl_ff, st_ff, sr_ff, sb_ff;
   logic [C-1:0]   cl_ff, ct_ff, cr_ff, cb_ff;
   logic [C-1:0]   dl, dt, dr, db;
   logic           disj_ff;
   logic signed [C:0] col_ff, row_ff, w1_ff, h1_ff;
   logic signed [C:0] w2, h2;
   logic signed [C:0] mul_a, mul_b;
   logic signed [PW-1:0] mul_p;
   logic signed [PW-1:0] inter_ff, pc_ff, ps_ff;
   logic signed [TW-1:0] ix, lhs, rhs;
   logic           join_ok;

   logic [SW-1:0]  sum_ff [4];
   logic [CW-1:0]  rem_ff [4];
   logic [CW-1:0]  cnt_ff;
   logic [DCW-1:0] div_cnt_ff;
   logic [MAX_ITEMS-1:0] pend;

   assign {dl, dt, dr, db} = rd_data_ff;
   assign rd_addr = cmd.rd_cand ? cand_ff[AW-1:0] : seed_ff[AW-1:0];

   // Write on load, read every cycle
   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         mem[count_ff[AW-1:0]] <= {req_left, req_top, req_right, req_bottom};
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Counters, indexes and assigned bits
   always_comb begin
      count_in    = count_ff;
      dropped_in  = dropped_ff;
      seed_in     = seed_ff;
      cand_in     = cand_ff;
      assigned_in = assigned_ff;
      if (cmd.load_wr) count_in = count_ff + CW'(1);
      if (cmd.drop)    dropped_in = 1'b1;
      if (cmd.seed_rst) seed_in = '0;
      if (cmd.seed_inc) seed_in = seed_ff + CW'(1);
      if (cmd.seed_take) begin
         cand_in = seed_ff + CW'(1);
         assigned_in[seed_ff[AW-1:0]] = 1'b1;
      end
      if (cmd.test && join_ok) assigned_in[cand_ff[AW-1:0]] = 1'b1;
      if (cmd.cand_inc) cand_in = cand_ff + CW'(1);
      if (cmd.clear) begin
         count_in    = '0;
         dropped_in  = 1'b0;
         assigned_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         dropped_ff  <= 1'b0;
         seed_ff     <= '0;
         cand_ff     <= '0;
         assigned_ff <= '0;
      end else begin
         count_ff    <= count_in;
         dropped_ff  <= dropped_in;
         seed_ff     <= seed_in;
         cand_ff     <= cand_in;
         assigned_ff <= assigned_in;
      end
   end

   // Capture seed box, then candidate geometry
   always_ff @(posedge clock) begin
      if (cmd.seed_take) begin
         sl_ff <= dl;
         st_ff <= dt;
         sr_ff <= dr;
         sb_ff <= db;
      end
      if (cmd.cmp_take) begin
         cl_ff   <= dl;
         ct_ff   <= dt;
         cr_ff   <= dr;
         cb_ff   <= db;
         disj_ff <= (sl_ff > dr) || (st_ff > db) || (sr_ff < dl) || (sb_ff < dt);
         col_ff  <= $signed({1'b0, (sr_ff < dr) ? sr_ff : dr})
                  - $signed({1'b0, (sl_ff > dl) ? sl_ff : dl});
         row_ff  <= $signed({1'b0, (sb_ff < db) ? sb_ff : db})
                  - $signed({1'b0, (st_ff > dt) ? st_ff : dt});
         w1_ff   <= $signed({1'b0, dr}) - $signed({1'b0, dl});
         h1_ff   <= $signed({1'b0, db}) - $signed({1'b0, dt});
      end
   end

   // Shared multiplier: intersection, candidate area, seed area
   assign w2 = $signed({1'b0, sr_ff}) - $signed({1'b0, sl_ff});
   assign h2 = $signed({1'b0, sb_ff}) - $signed({1'b0, st_ff});

   always_comb begin
      case (cmd.mul_sel)
         dwc_pkg::MUL_INTER: begin
            mul_a = col_ff;
            mul_b = row_ff;
         end
         dwc_pkg::MUL_CAND: begin
            mul_a = w1_ff;
            mul_b = h1_ff;
         end
         dwc_pkg::MUL_SEED: begin
            mul_a = w2;
            mul_b = h2;
         end
         default: begin
            mul_a = col_ff;
            mul_b = row_ff;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            dwc_pkg::MUL_INTER: inter_ff <= mul_p;
            dwc_pkg::MUL_CAND:  pc_ff    <= mul_p;
            dwc_pkg::MUL_SEED:  ps_ff    <= mul_p;
            default:            inter_ff <= mul_p;
         endcase
      end
   end

   // Join when 5*I > 2*(Aa + As - I), i.e. 7*I > 2*(Aa + As)
   assign ix      = TW'(inter_ff);
   assign lhs     = (ix <<< 3) - ix;
   assign rhs     = (TW'(pc_ff) + TW'(ps_ff)) <<< 1;
   assign join_ok = !disj_ff && (lhs > rhs);

   // Member sums, then restoring divide by member count in place
   always_ff @(posedge clock) begin
      if (cmd.seed_take) begin
         sum_ff[0]  <= SW'(dl);
         sum_ff[1]  <= SW'(dt);
         sum_ff[2]  <= SW'(dr);
         sum_ff[3]  <= SW'(db);
         rem_ff     <= '{default: '0};
         cnt_ff     <= CW'(1);
         div_cnt_ff <= '0;
      end else if (cmd.test && join_ok) begin
         sum_ff[0] <= sum_ff[0] + SW'(cl_ff);
         sum_ff[1] <= sum_ff[1] + SW'(ct_ff);
         sum_ff[2] <= sum_ff[2] + SW'(cr_ff);
         sum_ff[3] <= sum_ff[3] + SW'(cb_ff);
         cnt_ff    <= cnt_ff + CW'(1);
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + DCW'(1);
         for (int k = 0; k < 4; k++) begin
            if ({rem_ff[k], sum_ff[k][SW-1]} >= {1'b0, cnt_ff}) begin
               rem_ff[k] <= CW'({rem_ff[k], sum_ff[k][SW-1]} - {1'b0, cnt_ff});
               sum_ff[k] <= {sum_ff[k][SW-2:0], 1'b1};
            end else begin
               rem_ff[k] <= {rem_ff[k][CW-2:0], sum_ff[k][SW-1]};
               sum_ff[k] <= {sum_ff[k][SW-2:0], 1'b0};
            end
         end
      end
   end

   // Unassigned boxes after the current seed
   always_comb begin
      for (int j = 0; j < MAX_ITEMS; j++) begin
         pend[j] = !assigned_ff[j] && (CW'(j) > seed_ff) && (CW'(j) < count_ff);
      end
   end

   assign rsp_avg_left     = sum_ff[0][C-1:0];
   assign rsp_avg_top      = sum_ff[1][C-1:0];
   assign rsp_avg_right    = sum_ff[2][C-1:0];
   assign rsp_avg_bottom   = sum_ff[3][C-1:0];
   assign rsp_last_cluster = !(|pend);
   assign rsp_overflow     = dropped_ff;

   assign count_full        = (count_ff == CW'(MAX_ITEMS));
   assign sts.seed_end      = (seed_ff >= count_ff);
   assign sts.seed_assigned = assigned_ff[seed_ff[AW-1:0]];
   assign sts.cand_end      = (cand_ff >= count_ff);
   assign sts.cand_assigned = assigned_ff[cand_ff[AW-1:0]];
   assign sts.div_last      = (div_cnt_ff == DCW'(SW - 1));

endmodule
`default_nettype wire

### design/detection_window_clustering.sv
// Greedy IoU clustering of detection boxes. Load takes one beat per cycle; the last box
// starts grouping: per seed each later unassigned box is a candidate, tested through the
// shared multiplier (intersection, candidate area, seed area), then a divide per cluster.
// No boxes are accepted while a set is being grouped or its results are draining.
// Synchronous active-high reset empties the set and returns to loading; no clearing pass.
`default_nettype none
module detection_window_clustering #(
   parameter int MAX_ITEMS  = dwc_pkg::DEF_MAX_ITEMS,
   parameter int COORD_BITS = dwc_pkg::DEF_COORD_BITS
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire  [COORD_BITS-1:0] req_left,
   input  wire  [COORD_BITS-1:0] req_top,
   input  wire  [COORD_BITS-1:0] req_right,
   input  wire  [COORD_BITS-1:0] req_bottom,
   input  wire                   req_last_item,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic [COORD_BITS-1:0] rsp_avg_left,
   output logic [COORD_BITS-1:0] rsp_avg_top,
   output logic [COORD_BITS-1:0] rsp_avg_right,
   output logic [COORD_BITS-1:0] rsp_avg_bottom,
   output logic                  rsp_last_cluster,
   output logic                  rsp_overflow
);

   dwc_pkg::cmd_type    cmd;
   dwc_pkg::status_type sts;
   logic                count_full;

   dwc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_item (req_last_item),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .count_full    (count_full),
      .sts           (sts),
      .cmd           (cmd)
   );

   dwc_dpath #(
      .MAX_ITEMS  (MAX_ITEMS),
      .COORD_BITS (COORD_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .count_full       (count_full),
      .req_left         (req_left),
      .req_top          (req_top),
      .req_right        (req_right),
      .req_bottom       (req_bottom),
      .rsp_avg_left     (rsp_avg_left),
      .rsp_avg_top      (rsp_avg_top),
      .rsp_avg_right    (rsp_avg_right),
      .rsp_avg_bottom   (rsp_avg_bottom),
      .rsp_last_cluster (rsp_last_cluster),
      .rsp_overflow     (rsp_overflow)
   );

endmodule
`default_nettype wire

### design/dwc_checker.sv
// Port-level checks for detection_window_clustering, attached by bind.
// Depends on dwc_pkg for parameter defaults.
`default_nettype none
module dwc_checker #(
   parameter int COORD_BITS = dwc_pkg::DEF_COORD_BITS
) (
   input wire                  clock,
   input wire                  reset,
   input wire                  req_valid,
   input wire                  req_stall,
   input wire                  req_last_item,
   input wire                  rsp_valid,
   input wire                  rsp_stall,
   input wire [COORD_BITS-1:0] rsp_avg_left,
   input wire [COORD_BITS-1:0] rsp_avg_right,
   input wire                  rsp_last_cluster
);

   // Hold a stalled result beat: valid, left, right and last-cluster
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_avg_left)
         && $stable(rsp_avg_right) && $stable(rsp_last_cluster))
      else $error("stalled result beat changed");

   // No box is taken while results drain
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while result pending");

   // A box that is not last causes no result
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_last_item |=> !rsp_valid)
      else $error("result after a non-final box");

   // The final cluster closes the set
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_cluster |=> !rsp_valid)
      else $error("result after final cluster");

endmodule

bind detection_window_clustering dwc_checker #(.COORD_BITS(COORD_BITS)) u_dwc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_last_item    (req_last_item),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_avg_left     (rsp_avg_left),
   .rsp_avg_right    (rsp_avg_right),
   .rsp_last_cluster (rsp_last_cluster)
);
`default_nettype wire

### bench/detection_window_clustering_tb.sv
// Self-checking bench for detection_window_clustering: loads rectangle sets, predicts the
// greedy IoU grouping and averaged clusters, and compares every result beat.
// Depends on dwc_pkg and the detection_window_clustering RTL only.
`timescale 1ns / 100ps
module detection_window_clustering_tb;

   localparam int NBOX  = dwc_pkg::DEF_MAX_ITEMS;
   localparam int CBITS = dwc_pkg::DEF_COORD_BITS;
   localparam int IDLE_LIMIT = 200000;

   typedef logic [CBITS-1:0] coord_type;
   typedef struct {
      coord_type l, t, r, b;
   } rect_type;
   typedef struct {
      coord_type l, t, r, b;
      logic   last, ovf;
   } cluster_type;

   logic   clock = 1'b0;
   logic   reset = 1'b1;
   logic   req_valid = 1'b0;
   logic   req_stall;
   coord_type req_left = '0, req_top = '0, req_right = '0, req_bottom = '0;
   logic   req_last_item = 1'b0;
   logic   rsp_valid;
   logic   rsp_stall = 1'b0;
   coord_type rsp_avg_left, rsp_avg_top, rsp_avg_right, rsp_avg_bottom;
   logic   rsp_last_cluster, rsp_overflow;

   // grouping state of the predictor
   rect_type    pending_boxes[$];
   logic        pending_dropped = 1'b0;
   cluster_type expected_clusters[$];

   bit quiet = 1'b0;
   int errors = 0;
   int boxes_sent = 0;
   int sets_sent = 0;
   int clusters_seen = 0;
   int idle_cycles = 0;
   int stall_burst = 0;

   detection_window_clustering dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_left(req_left), .req_top(req_top), .req_right(req_right),
      .req_bottom(req_bottom), .req_last_item(req_last_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_avg_left(rsp_avg_left), .rsp_avg_top(rsp_avg_top),
      .rsp_avg_right(rsp_avg_right), .rsp_avg_bottom(rsp_avg_bottom),
      .rsp_last_cluster(rsp_last_cluster), .rsp_overflow(rsp_overflow)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // IoU above 0.4 against the seed, exact integer form
   function automatic bit overlaps_seed(rect_type a, rect_type s);
      longint al, at, ar, ab, sl, st, sr, sb;
      longint w1, h1, w2, h2, col, row, inter, uni;
      al = a.l; at = a.t; ar = a.r; ab = a.b;
      sl = s.l; st = s.t; sr = s.r; sb = s.b;
      w1 = ar - al; h1 = ab - at; w2 = sr - sl; h2 = sb - st;
      if (sl > al + w1 || st > at + h1 || sl + w2 < al || st + h2 < at) return 1'b0;
      col = ((sr < ar) ? sr : ar) - ((sl > al) ? sl : al);
      row = ((sb < ab) ? sb : ab) - ((st > at) ? st : at);
      inter = col * row;
      uni = w2 * h2 + w1 * h1 - inter;
      return 5 * inter > 2 * uni;
   endfunction

   // store one accepted box; on the closing box group the set and queue its clusters
   function automatic void predict_box(rect_type bx, logic last);
      int     label[NBOX];
      int     n, nclus, cnt;
      longint sl, st, sr, sb;
      cluster_type c;
      if (pending_boxes.size() < NBOX) pending_boxes.push_back(bx);
      else pending_dropped = 1'b1;
      if (!last) return;
      n = pending_boxes.size();
      nclus = 0;
      foreach (label[k]) label[k] = 0;
      for (int i = 0; i < n; i++) begin
         if (label[i] != 0) continue;
         nclus++;
         label[i] = nclus;
         for (int j = i + 1; j < n; j++)
            if (label[j] == 0 && overlaps_seed(pending_boxes[j], pending_boxes[i]))
               label[j] = nclus;
      end
      for (int ci = 1; ci <= nclus; ci++) begin
         sl = 0; st = 0; sr = 0; sb = 0; cnt = 0;
         for (int j = 0; j < n; j++) begin
            if (label[j] == ci) begin
               sl += pending_boxes[j].l; st += pending_boxes[j].t;
               sr += pending_boxes[j].r; sb += pending_boxes[j].b;
               cnt++;
            end
         end
         c.l = coord_type'(sl / cnt); c.t = coord_type'(st / cnt);
         c.r = coord_type'(sr / cnt); c.b = coord_type'(sb / cnt);
         c.last = (ci == nclus);
         c.ovf = pending_dropped;
         expected_clusters.push_back(c);
      end
      pending_boxes.delete();
      pending_dropped = 1'b0;
   endfunction

   // drive one box beat, with an optional idle burst first, and hold until accepted
   task automatic send_box(rect_type bx, logic last);
      int gap;
      gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_left <= bx.l; req_top <= bx.t; req_right <= bx.r; req_bottom <= bx.b;
      req_last_item <= last;
      do @(posedge clock); while (req_stall);
      predict_box(bx, last);
      boxes_sent++;
      if (last) sets_sent++;
   endtask

   function automatic rect_type make_rect(int l, int t, int r, int b);
      rect_type x;
      x.l = coord_type'(l); x.t = coord_type'(t);
      x.r = coord_type'(r); x.b = coord_type'(b);
      return x;
   endfunction

   // small jitter of an existing box, usually enough to stay in its cluster
   function automatic rect_type jitter(rect_type s, int amt);
      return make_rect(s.l + $urandom_range(0, 2 * amt) - amt,
                       s.t + $urandom_range(0, 2 * amt) - amt,
                       s.r + $urandom_range(0, 2 * amt) - amt,
                       s.b + $urandom_range(0, 2 * amt) - amt);
   endfunction

   function automatic rect_type random_rect();
      int l, t;
      l = $urandom_range(0, 32767);
      t = $urandom_range(0, 32767);
      case ($urandom_range(0, 5))
         0: return make_rect($urandom, $urandom, $urandom, $urandom);
         1: return make_rect(l, t, l, t);
         default: return make_rect(l, t, l + $urandom_range(1, 3000),
                                   t + $urandom_range(1, 3000));
      endcase
   endfunction

   // send a set of boxes built around a few seeds
   task automatic send_set(int n);
      rect_type seeds[$];
      rect_type bx;
      for (int i = 0; i < n; i++) begin
         if (seeds.size() == 0 || $urandom_range(0, 9) < 3) begin
            bx = random_rect();
            seeds.push_back(bx);
         end else begin
            bx = jitter(seeds[$urandom_range(0, seeds.size() - 1)], $urandom_range(1, 40));
         end
         send_box(bx, i == n - 1);
      end
   endtask

   task automatic test_directed();
      // single box set, full-range extremes
      send_box(make_rect(0, 0, 32767, 32767), 1'b1);
      // identical boxes merge, touching boxes stay apart
      send_box(make_rect(100, 100, 200, 200), 1'b0);
      send_box(make_rect(100, 100, 200, 200), 1'b0);
      send_box(make_rect(200, 100, 300, 200), 1'b0);
      send_box(make_rect(100, 200, 200, 300), 1'b1);
      // degenerate boxes with zero union
      send_box(make_rect(500, 500, 500, 500), 1'b0);
      send_box(make_rect(500, 500, 500, 500), 1'b0);
      send_box(make_rect(32767, 32767, 32767, 32767), 1'b1);
      // inverted rectangles and disjoint edges
      send_box(make_rect(300, 300, 100, 100), 1'b0);
      send_box(make_rect(300, 300, 100, 100), 1'b0);
      send_box(make_rect(290, 310, 110, 90), 1'b0);
      send_box(make_rect(0, 32767, 32767, 0), 1'b0);
      send_box(make_rect(32767, 0, 0, 32767), 1'b1);
      // IoU right at the threshold and just past it
      send_box(make_rect(0, 0, 10, 10), 1'b0);
      send_box(make_rect(0, 0, 10, 4), 1'b0);
      send_box(make_rect(0, 0, 10, 5), 1'b1);
      // bit patterns
      send_box(make_rect(15'h5555, 15'h2aaa, 15'h7fff, 15'h7ffe), 1'b0);
      send_box(make_rect(15'h2aaa, 15'h5555, 15'h4000, 15'h0001), 1'b1);
   endtask

   task automatic test_overflow();
      // fill past capacity, closing box dropped as well
      send_set(NBOX + 3);
      // exactly full set
      send_set(NBOX);
   endtask

   task automatic test_random(int target);
      while (boxes_sent < target)
         send_set(($urandom_range(0, 15) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 10));
   endtask

   task automatic test_quiet_tail();
      quiet = 1'b1;
      repeat (5) send_set($urandom_range(1, 8));
   endtask

   // receiver back-pressure in bursts
   always @(negedge clock) begin
      if (stall_burst > 0) stall_burst--;
      else if (!quiet && $urandom_range(0, 5) == 0) stall_burst = $urandom_range(1, 4);
      rsp_stall <= (stall_burst > 0);
   end

   // compare each accepted result beat with the oldest expected cluster
   always @(posedge clock) begin
      cluster_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         clusters_seen++;
         if (expected_clusters.size() == 0) begin
            $error("unexpected cluster beat");
            errors++;
         end else begin
            e = expected_clusters.pop_front();
            if (rsp_avg_left !== e.l) begin
               $error("avg_left exp %0d got %0d", e.l, rsp_avg_left); errors++;
            end
            if (rsp_avg_top !== e.t) begin
               $error("avg_top exp %0d got %0d", e.t, rsp_avg_top); errors++;
            end
            if (rsp_avg_right !== e.r) begin
               $error("avg_right exp %0d got %0d", e.r, rsp_avg_right); errors++;
            end
            if (rsp_avg_bottom !== e.b) begin
               $error("avg_bottom exp %0d got %0d", e.b, rsp_avg_bottom); errors++;
            end
            if (rsp_last_cluster !== e.last) begin
               $error("last_cluster exp %0d got %0d", e.last, rsp_last_cluster); errors++;
            end
            if (rsp_overflow !== e.ovf) begin
               $error("overflow exp %0d got %0d", e.ovf, rsp_overflow); errors++;
            end
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("detection_window_clustering regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_overflow();
      test_random(300);
      test_quiet_tail();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_clusters.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Covered %0d sets, %0d boxes, %0d cluster beats checked, %0d mismatches.",
               sets_sent, boxes_sent, clusters_seen, errors);
      if (errors == 0 && expected_clusters.size() == 0)
         $display("detection_window_clustering regression: pass");
      else
         $display("detection_window_clustering regression: fail");
      $finish;
   end

endmodule
